// ===== sv/bftm_pkg.sv =====
// ----------------------------------------------------------------------------
// bftm_pkg
// shared types and codes of the eight-command tape machine: request codes,
// command characters, error codes, register map and the word structs
// ----------------------------------------------------------------------------
package bftm_pkg;

  localparam int PC_W    = 13;
  localparam int STK_W   = 12;
  localparam int ADDR_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int ERR_W   = 3;
  localparam int REQ_W   = 2;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // command characters
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_PAST_END   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BELOW_ZERO = 3'd2;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd4;

  // register map
  localparam logic [PADDR_W-1:0] REG_PROG_LEN = 2'd0;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] prog_addr;
    logic [BYTE_W-1:0] prog_char;
    logic [BYTE_W-1:0] in_byte;
    logic              in_eof;
  } bftm_in_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              input_taken;
    logic              halted;
    logic [ERR_W-1:0]  error_code;
    logic [PC_W-1:0]   pc_now;
  } bftm_out_t;

endpackage

// ===== sv/bftm_mem.sv =====
// ----------------------------------------------------------------------------
// bftm_mem
// single-port-write, single-port-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module bftm_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bftm_cfg.sv =====
// ----------------------------------------------------------------------------
// bftm_cfg
// apb register slave holding the program length register
// ----------------------------------------------------------------------------
module bftm_cfg
  import bftm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [PC_W-1:0]    prog_len
);

  logic [PC_W-1:0] prog_len_r;
  logic [PC_W-1:0] prog_len_nxt;

  always_comb begin
    prog_len_nxt = prog_len_r;
    if (psel && penable && pwrite && (paddr == REG_PROG_LEN)) begin
      prog_len_nxt = pwdata[PC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else begin
      prog_len_r <= prog_len_nxt;
    end
  end

  assign prdata   = (paddr == REG_PROG_LEN) ? {{(PDATA_W-PC_W){1'b0}}, prog_len_r} : '0;
  assign pready   = 1'b1;
  assign prog_len = prog_len_r;

endmodule

// ===== sv/bf_tape_machine_step.sv =====
// ----------------------------------------------------------------------------
// bf_tape_machine_step
// eight-command tape machine: program store, tape and loop stack in rams,
// one command per step word under a small sequencer sharing one pc adder
//
//   channel   ports                                  handshake
//   input     start, busy, in_item                   start && !busy
//   result    out_strobe, out_item                   one-cycle strobe
//   config    psel, penable, pwrite, paddr, pwdata,  apb, pready always 1
//             prdata, pready
//
// load, idle and halted-step words: accept leads straight to the respond state, which registers the result strobe
// ordinary step: program, tape and stack read, then execute, then respond
// skipped loop: a scan read and a scan check per program character scanned, one more scan read when no match
// start: tape clear sweep over all TAPE_DEPTH cells, then the respond state and the result
// after reset the same clear sweep runs (busy high)
// the receiver cannot stall; a new word may be accepted while a result shows
// ----------------------------------------------------------------------------
module bf_tape_machine_step
  import bftm_pkg::*;
#(
  parameter int TAPE_DEPTH  = 30000,
  parameter int PROG_DEPTH  = 4096,
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bftm_in_t           in_item,
  output logic               out_strobe,
  output bftm_out_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int TP_W = $clog2(TAPE_DEPTH);
  localparam int PA_W = $clog2(PROG_DEPTH);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CHK = 3'd3;
  localparam logic [2:0] S_CLR      = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [TP_W-1:0]   ptr_r, ptr_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              halt_r, halt_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [TP_W-1:0]   clr_r, clr_nxt;
  logic [PC_W-1:0]   depth_r, depth_nxt;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              it_r, it_nxt;
  logic [BYTE_W-1:0] inb_r, inb_nxt;
  logic              eof_r, eof_nxt;
  bftm_out_t         out_r, out_nxt;
  logic              strobe_r, strobe_nxt;

  logic [PC_W-1:0]   prog_len;
  logic [PC_W-1:0]   len_eff;
  logic              accept;
  logic [PC_W-1:0]   pc_base;
  logic [PC_W-1:0]   pc_inc;
  logic              halt_fin;

  logic              prog_we;
  logic [PA_W-1:0]   prog_raddr;
  logic [BYTE_W-1:0] cmd;
  logic              tape_we;
  logic [TP_W-1:0]   tape_waddr;
  logic [BYTE_W-1:0] tape_wdata;
  logic [BYTE_W-1:0] cell_val;
  logic              stk_we;
  logic [SA_W-1:0]   stk_raddr;
  logic [STK_W-1:0]  stk_top;

  bftm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .prog_len (prog_len)
  );

  bftm_mem #(.DEPTH(PROG_DEPTH), .WIDTH(BYTE_W)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (PA_W'(in_item.prog_addr)),
    .wdata (in_item.prog_char),
    .raddr (prog_raddr),
    .rdata (cmd)
  );

  bftm_mem #(.DEPTH(TAPE_DEPTH), .WIDTH(BYTE_W)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (ptr_r),
    .rdata (cell_val)
  );

  bftm_mem #(.DEPTH(STACK_DEPTH), .WIDTH(STK_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (SA_W'(sp_r)),
    .wdata (pc_r[STK_W-1:0]),
    .raddr (stk_raddr),
    .rdata (stk_top)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign len_eff = (32'(prog_len) < PROG_DEPTH) ? prog_len : PC_W'(PROG_DEPTH);

  // the one pc adder: step advance, jump back to the loop head and the bracket search
  assign pc_base = (state_r == S_EXEC && cmd == CH_CLOSE && cell_val != '0) ?
                   {1'b0, stk_top} : pc_r;
  assign pc_inc  = pc_base + 1'b1;

  assign halt_fin = halt_r || ((req_r == REQ_STEP) && (pc_r >= len_eff));

  assign stk_raddr  = SA_W'(sp_r - 1'b1);
  assign tape_waddr = (state_r == S_CLR) ? clr_r : ptr_r;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    pc_nxt     = pc_r;
    ptr_nxt    = ptr_r;
    sp_nxt     = sp_r;
    halt_nxt   = halt_r;
    err_nxt    = err_r;
    clr_nxt    = clr_r;
    depth_nxt  = depth_r;
    ov_nxt     = ov_r;
    ob_nxt     = ob_r;
    it_nxt     = it_r;
    inb_nxt    = inb_r;
    eof_nxt    = eof_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    prog_we    = 1'b0;
    prog_raddr = PA_W'(pc_r);
    tape_we    = 1'b0;
    tape_wdata = '0;
    stk_we     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_item.req_type;
          ov_nxt  = 1'b0;
          ob_nxt  = '0;
          it_nxt  = 1'b0;
          inb_nxt = in_item.in_byte;
          eof_nxt = in_item.in_eof;
          case (in_item.req_type)
            REQ_LOAD: begin
              prog_we   = (32'(in_item.prog_addr) < PROG_DEPTH);
              state_nxt = S_RESP;
            end
            REQ_START: begin
              ptr_nxt   = '0;
              pc_nxt    = '0;
              sp_nxt    = '0;
              halt_nxt  = 1'b0;
              err_nxt   = ERR_NONE;
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            REQ_STEP: begin
              state_nxt = (halt_r || pc_r >= len_eff) ? S_RESP : S_EXEC;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_EXEC: begin
        state_nxt = S_RESP;
        case (cmd)
          CH_RIGHT: begin
            if (32'(ptr_r) + 32'd1 >= TAPE_DEPTH) begin
              err_nxt  = ERR_PAST_END;
              halt_nxt = 1'b1;
            end else begin
              ptr_nxt = ptr_r + 1'b1;
              pc_nxt  = pc_inc;
            end
          end
          CH_LEFT: begin
            if (ptr_r == '0) begin
              err_nxt  = ERR_BELOW_ZERO;
              halt_nxt = 1'b1;
            end else begin
              ptr_nxt = ptr_r - 1'b1;
              pc_nxt  = pc_inc;
            end
          end
          CH_INC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_val + 1'b1;
            pc_nxt     = pc_inc;
          end
          CH_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = cell_val - 1'b1;
            pc_nxt     = pc_inc;
          end
          CH_OUT: begin
            ov_nxt = 1'b1;
            ob_nxt = cell_val;
            pc_nxt = pc_inc;
          end
          CH_IN: begin
            it_nxt     = 1'b1;
            tape_we    = 1'b1;
            tape_wdata = eof_r ? '1 : inb_r;
            pc_nxt     = pc_inc;
          end
          CH_OPEN: begin
            if (cell_val == '0) begin
              depth_nxt = PC_W'(1);
              state_nxt = S_SCAN_RD;
            end else if (32'(sp_r) >= STACK_DEPTH) begin
              err_nxt  = ERR_OVERFLOW;
              halt_nxt = 1'b1;
            end else begin
              stk_we = 1'b1;
              sp_nxt = sp_r + 1'b1;
              pc_nxt = pc_inc;
            end
          end
          CH_CLOSE: begin
            if (sp_r == '0) begin
              err_nxt  = ERR_UNMATCHED;
              halt_nxt = 1'b1;
            end else begin
              // pc_inc already starts from the loop head when the cell is nonzero
              if (cell_val == '0) begin
                sp_nxt = sp_r - 1'b1;
              end
              pc_nxt = pc_inc;
            end
          end
          default: begin
            pc_nxt = pc_inc;
          end
        endcase
      end

      S_SCAN_RD: begin
        if (pc_inc < len_eff) begin
          prog_raddr = PA_W'(pc_inc);
          pc_nxt     = pc_inc;
          state_nxt  = S_SCAN_CHK;
        end else begin
          // no matching close before the end of the program
          pc_nxt    = len_eff;
          state_nxt = S_RESP;
        end
      end

      S_SCAN_CHK: begin
        state_nxt = S_SCAN_RD;
        if (cmd == CH_OPEN) begin
          depth_nxt = depth_r + 1'b1;
        end else if (cmd == CH_CLOSE) begin
          if (depth_r == PC_W'(1)) begin
            pc_nxt    = pc_inc;
            state_nxt = S_RESP;
          end else begin
            depth_nxt = depth_r - 1'b1;
          end
        end
      end

      S_CLR: begin
        tape_we = 1'b1;
        if (32'(clr_r) == TAPE_DEPTH - 1) begin
          state_nxt = (req_r == REQ_START) ? S_RESP : S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_RESP: begin
        halt_nxt            = halt_fin;
        out_nxt.out_valid   = ov_r;
        out_nxt.out_byte    = ob_r;
        out_nxt.input_taken = it_r;
        out_nxt.halted      = halt_fin || (pc_r >= len_eff);
        out_nxt.error_code  = err_r;
        out_nxt.pc_now      = pc_r;
        strobe_nxt          = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      req_r    <= REQ_NONE;
      pc_r     <= '0;
      ptr_r    <= '0;
      sp_r     <= '0;
      halt_r   <= 1'b0;
      err_r    <= ERR_NONE;
      clr_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      req_r    <= req_nxt;
      pc_r     <= pc_nxt;
      ptr_r    <= ptr_nxt;
      sp_r     <= sp_nxt;
      halt_r   <= halt_nxt;
      err_r    <= err_nxt;
      clr_r    <= clr_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    depth_r <= depth_nxt;
    ov_r    <= ov_nxt;
    ob_r    <= ob_nxt;
    it_r    <= it_nxt;
    inb_r   <= inb_nxt;
    eof_r   <= eof_nxt;
    out_r   <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  // a result word always closes a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a preceding busy period");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |-> halt_r)
    else $error("error code set while machine not halted");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= STACK_DEPTH)
    else $error("loop stack count past its depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < TAPE_DEPTH)
    else $error("tape pointer outside the tape");

endmodule
